[rtl/spa_pkg.sv]
// ============================================================================
// spa_pkg: shared types and constants of the sparse polynomial adder
// Holds the request kinds, the term layout, the control states and the
// saturating coefficient adder.
// ============================================================================
`default_nettype none

package spa_pkg;

  localparam int COEF_W = 32;
  localparam int EXP_W  = 16;

  // Request kinds carried in the input tuser.
  typedef enum logic [1:0] {
    KIND_LOAD_P = 2'd0,
    KIND_LOAD_Q = 2'd1,
    KIND_RUN    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // One stored term; the coefficient sits in the low bits.
  typedef struct packed {
    logic [EXP_W-1:0]         exponent;
    logic signed [COEF_W-1:0] coef;
  } term_t;

  // Control states of the merge sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MERGE,
    ST_FLUSH
  } state_t;

  // Signed add that clamps to the coefficient range.
  function automatic logic signed [COEF_W-1:0] sat_add(
    input logic signed [COEF_W-1:0] a,
    input logic signed [COEF_W-1:0] b
  );
    logic signed [COEF_W:0] s;
    logic signed [COEF_W-1:0] r;
    s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
    if (s[COEF_W] != s[COEF_W-1]) begin
      r = s[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      r = s[COEF_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/sparse_polynomial_adder_top.sv]
// ============================================================================
// sparse_polynomial_adder_top: merge-add of two sparse polynomials
// Stores two term lists in small synchronous memories and merges them in
// descending exponent order on a run request.
// ============================================================================
// Usage:
//   Input stream (s_*): tuser selects the request kind: load a term of P,
//   load a term of Q, or run. tdata carries the coefficient and exponent of
//   a load. Loads are taken one per cycle while no run is in progress; a
//   load into a full list is ignored and sets the overflow mark.
//   A run walks both lists with one memory read per list; each merge step
//   reads in ST_READ, then compares and adds in ST_MERGE, and the run
//   finishes with a last ST_READ and ST_FLUSH. Each emitted sum term leaves
//   through a registered output, as does the single empty-marked request of
//   a run without terms.
//   The output stream (m_*) carries one request per sum term, tlast on the
//   final one; a run whose terms all cancel gives one empty-marked request.
//   On a receiver stall, a merge step that must release a held term waits.
//   After a run both lists are empty and the overflow mark is cleared.
//   Reset empties both lists, clears the overflow mark and drops any
//   pending output; stored terms are not cleared.
// ============================================================================
`default_nettype none

module sparse_polynomial_adder_top #(
  parameter int TERMS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // [31:0] term_coef, [47:32] term_exponent
  input  wire logic [1:0]  s_tuser,   // [1:0] kind
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [31:0] sum_coef, [47:32] sum_exponent
  output logic             m_tlast,
  output logic [1:0]       m_tuser    // [0] empty_res, [1] overflow
);

  localparam int CNT_W = $clog2(TERMS + 1);
  localparam int IDX_W = (TERMS > 1) ? $clog2(TERMS) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TERMS);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Term memories.
  spa_pkg::term_t p_mem [TERMS];
  spa_pkg::term_t q_mem [TERMS];
  spa_pkg::term_t p_rd;
  spa_pkg::term_t q_rd;

  // Control and datapath registers.
  spa_pkg::state_t state;
  spa_pkg::state_t state_next;
  logic [CNT_W-1:0] p_count;
  logic [CNT_W-1:0] q_count;
  logic [CNT_W-1:0] p_idx;
  logic [CNT_W-1:0] q_idx;
  logic             dropped;
  logic             hold_valid;
  spa_pkg::term_t   hold_term;
  spa_pkg::term_t   out_term;
  logic             out_last;
  logic             out_empty;
  logic             out_ovf;

  // Combinational controls.
  spa_pkg::kind_t   in_kind;
  spa_pkg::term_t   in_term;
  logic             in_fire;
  logic             p_avail;
  logic             q_avail;
  logic             take_p;
  logic             take_q;
  logic             take_both;
  logic signed [spa_pkg::COEF_W-1:0] sum_coef;
  spa_pkg::term_t   new_term;
  logic             new_emit;
  logic             slot_free;
  logic             merge_go;
  logic             push_hold;
  logic             flush_go;
  logic             run_done;

  assign in_kind = spa_pkg::kind_t'(s_tuser);
  assign in_term = spa_pkg::term_t'(s_tdata);
  assign in_fire = s_tvalid && s_tready;

  // Merge decision on the terms read for the current indexes.
  assign p_avail   = p_idx < p_count;
  assign q_avail   = q_idx < q_count;
  assign take_both = p_avail && q_avail && (p_rd.exponent == q_rd.exponent);
  assign take_p    = p_avail && (!q_avail || (p_rd.exponent > q_rd.exponent));
  assign take_q    = q_avail && (!p_avail || (q_rd.exponent > p_rd.exponent));
  assign sum_coef  = spa_pkg::sat_add(p_rd.coef, q_rd.coef);

  always_comb begin
    new_term = q_rd;
    if (take_both) begin
      new_term.coef     = sum_coef;
      new_term.exponent = p_rd.exponent;
    end else if (take_p) begin
      new_term = p_rd;
    end
  end

  assign new_emit  = !take_both || (sum_coef != '0);
  assign slot_free = !m_tvalid || m_tready;
  assign run_done  = !p_avail && !q_avail;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      spa_pkg::ST_IDLE: begin
        if (in_fire && (in_kind == spa_pkg::KIND_RUN)) begin
          state_next = spa_pkg::ST_READ;
        end
      end
      spa_pkg::ST_READ: begin
        state_next = run_done ? spa_pkg::ST_FLUSH : spa_pkg::ST_MERGE;
      end
      spa_pkg::ST_MERGE: begin
        if (merge_go) begin
          state_next = spa_pkg::ST_READ;
        end
      end
      spa_pkg::ST_FLUSH: begin
        if (slot_free) begin
          state_next = spa_pkg::ST_IDLE;
        end
      end
      default: state_next = spa_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_tready  = 1'b0;
    merge_go  = 1'b0;
    push_hold = 1'b0;
    flush_go  = 1'b0;
    case (state)
      spa_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      spa_pkg::ST_MERGE: begin
        merge_go  = !(new_emit && hold_valid) || slot_free;
        push_hold = new_emit && hold_valid && slot_free;
      end
      spa_pkg::ST_FLUSH: begin
        flush_go = slot_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Memory writes on loads, reads at the merge indexes.
  always_ff @(posedge clk) begin
    if (in_fire && (in_kind == spa_pkg::KIND_LOAD_P) && (p_count < CNT_FULL)) begin
      p_mem[p_count[IDX_W-1:0]] <= in_term;
    end
    if (in_fire && (in_kind == spa_pkg::KIND_LOAD_Q) && (q_count < CNT_FULL)) begin
      q_mem[q_count[IDX_W-1:0]] <= in_term;
    end
    p_rd <= p_mem[p_idx[IDX_W-1:0]];
    q_rd <= q_mem[q_idx[IDX_W-1:0]];
  end

  // List counts, overflow mark and merge indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_count <= '0;
      q_count <= '0;
      dropped <= 1'b0;
      p_idx   <= '0;
      q_idx   <= '0;
    end else begin
      if (in_fire && (in_kind == spa_pkg::KIND_LOAD_P)) begin
        if (p_count < CNT_FULL) begin
          p_count <= p_count + CNT_ONE;
        end else begin
          dropped <= 1'b1;
        end
      end
      if (in_fire && (in_kind == spa_pkg::KIND_LOAD_Q)) begin
        if (q_count < CNT_FULL) begin
          q_count <= q_count + CNT_ONE;
        end else begin
          dropped <= 1'b1;
        end
      end
      if (in_fire && (in_kind == spa_pkg::KIND_RUN)) begin
        p_idx <= '0;
        q_idx <= '0;
      end
      if (merge_go) begin
        if (take_p || take_both) begin
          p_idx <= p_idx + CNT_ONE;
        end
        if (take_q || take_both) begin
          q_idx <= q_idx + CNT_ONE;
        end
      end
      if (flush_go) begin
        p_count <= '0;
        q_count <= '0;
        dropped <= 1'b0;
      end
    end
  end

  // One-term hold: a term is released only once the next one is known,
  // so the final term of a run can carry tlast.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (flush_go) begin
      hold_valid <= 1'b0;
    end else if (merge_go && new_emit) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (merge_go && new_emit) begin
      hold_term <= new_term;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push_hold || flush_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_hold) begin
      out_term  <= hold_term;
      out_last  <= 1'b0;
      out_empty <= 1'b0;
      out_ovf   <= dropped;
    end else if (flush_go) begin
      out_term  <= hold_valid ? hold_term : '0;
      out_last  <= 1'b1;
      out_empty <= !hold_valid;
      out_ovf   <= dropped;
    end
  end

  assign m_tdata = out_term;
  assign m_tlast = out_last;
  assign m_tuser = {out_ovf, out_empty};

endmodule

`default_nettype wire
